@@ rtl/lls3d_pkg.sv @@
// Shared types and constants for the 3D Laplacian stencil block.
package lls3d_pkg;

  // register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_DIM_X  = 3'd1;
  localparam logic [2:0] REG_DIM_Y  = 3'd2;
  localparam logic [2:0] REG_DIM_Z  = 3'd3;
  localparam logic [2:0] REG_CENTER = 3'd4;
  localparam logic [2:0] REG_COEF_X = 3'd5;
  localparam logic [2:0] REG_COEF_Y = 3'd6;
  localparam logic [2:0] REG_COEF_Z = 3'd7;

  localparam int CFG_WIDTH = 32;
  localparam int COEF_WIDTH = 32;
  localparam int ACC_WIDTH = 112;

  typedef enum logic [1:0] {
    MODE_ORTHO = 2'd0,
    MODE_BCC   = 2'd1,
    MODE_FCC   = 2'd2,
    MODE_HEX   = 2'd3
  } lattice_mode_t;

  // weight selection of one tap
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_X    = 2'd1,
    SEL_Y    = 2'd2,
    SEL_Z    = 2'd3
  } coef_sel_t;

  // stencil geometry: x and y address increments
  typedef struct packed {
    logic [15:0] incx;
    logic [7:0]  incy;
  } geom_t;

  // weight selection for a lattice mode and a tap slot (13 slots); offsets come from tap_off
  function automatic coef_sel_t tap_sel(input lattice_mode_t m, input logic [3:0] t);
    coef_sel_t s;
    s = SEL_NONE;
    unique case (m)
      MODE_ORTHO: begin
        if (t < 4'd2) s = SEL_X;
        else if (t < 4'd4) s = SEL_Y;
        else if (t < 4'd6) s = SEL_Z;
      end
      MODE_BCC: if (t < 4'd8) s = SEL_X;
      MODE_FCC: if (t < 4'd12) s = SEL_X;
      MODE_HEX: begin
        if (t < 4'd6) s = SEL_X;
        else if (t < 4'd8) s = SEL_Z;
      end
      default: s = SEL_NONE;
    endcase
    return s;
  endfunction

  // packed offset {dx,dy,dz}, each 2-bit signed
  function automatic logic [5:0] tap_off(input lattice_mode_t m, input logic [3:0] t);
    logic [5:0] o;
    o = 6'b000000;
    unique case (m)
      MODE_ORTHO: begin
        case (t)
          4'd0: o = {2'b11, 2'b00, 2'b00};
          4'd1: o = {2'b01, 2'b00, 2'b00};
          4'd2: o = {2'b00, 2'b11, 2'b00};
          4'd3: o = {2'b00, 2'b01, 2'b00};
          4'd4: o = {2'b00, 2'b00, 2'b11};
          4'd5: o = {2'b00, 2'b00, 2'b01};
          default: o = 6'b000000;
        endcase
      end
      MODE_BCC: begin
        case (t)
          4'd0: o = {2'b11, 2'b11, 2'b11};
          4'd1: o = {2'b11, 2'b00, 2'b00};
          4'd2: o = {2'b00, 2'b11, 2'b00};
          4'd3: o = {2'b00, 2'b00, 2'b11};
          4'd4: o = {2'b00, 2'b00, 2'b01};
          4'd5: o = {2'b00, 2'b01, 2'b00};
          4'd6: o = {2'b01, 2'b00, 2'b00};
          4'd7: o = {2'b01, 2'b01, 2'b01};
          default: o = 6'b000000;
        endcase
      end
      MODE_FCC: begin
        case (t)
          4'd0:  o = {2'b11, 2'b00, 2'b00};
          4'd1:  o = {2'b11, 2'b00, 2'b01};
          4'd2:  o = {2'b11, 2'b01, 2'b00};
          4'd3:  o = {2'b00, 2'b11, 2'b00};
          4'd4:  o = {2'b00, 2'b11, 2'b01};
          4'd5:  o = {2'b00, 2'b00, 2'b11};
          4'd6:  o = {2'b00, 2'b00, 2'b01};
          4'd7:  o = {2'b00, 2'b01, 2'b11};
          4'd8:  o = {2'b00, 2'b01, 2'b00};
          4'd9:  o = {2'b01, 2'b11, 2'b00};
          4'd10: o = {2'b01, 2'b00, 2'b11};
          4'd11: o = {2'b01, 2'b00, 2'b00};
          default: o = 6'b000000;
        endcase
      end
      MODE_HEX: begin
        case (t)
          4'd0: o = {2'b01, 2'b00, 2'b00};
          4'd1: o = {2'b01, 2'b11, 2'b00};
          4'd2: o = {2'b00, 2'b11, 2'b00};
          4'd3: o = {2'b11, 2'b00, 2'b00};
          4'd4: o = {2'b11, 2'b01, 2'b00};
          4'd5: o = {2'b00, 2'b01, 2'b00};
          4'd6: o = {2'b00, 2'b00, 2'b11};
          4'd7: o = {2'b00, 2'b00, 2'b01};
          default: o = 6'b000000;
        endcase
      end
      default: o = 6'b000000;
    endcase
    return o;
  endfunction

endpackage

@@ rtl/lls3d_stream_if.sv @@
// Valid/ready stream channel carrying one payload word.
interface lls3d_stream_if #(
  parameter int WIDTH = 32
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lls3d_result_if.sv @@
// Valid/ready result channel: laplacian plus last-point flag.
interface lls3d_result_if #(
  parameter int WIDTH = 32
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] laplacian;
  logic             last_point;

  modport source (output valid, output laplacian, output last_point, input ready);
  modport sink (input valid, input laplacian, input last_point, output ready);
endinterface

@@ rtl/lattice_laplacian_stencil_3d_top.sv @@
// Top level of the streaming 3D Laplacian stencil engine.
//  channel  dir  kind         payload
//  in       in   valid/ready  sample
//  out      out  valid/ready  laplacian, last_point
//  cfg      in   write only   cfg_we, cfg_index, cfg_data
// One word is taken every clock unless the output stalls; the row of fourteen
// cells adds one weighted neighbor each, and the rounded, saturated sum is held
// in the output register until it is taken.
// The whole row advances together and stops when the output register is full
// and not being taken. Reset clears position, write pointer and valid flags;
// window entries are not cleared.
module lattice_laplacian_stencil_3d_top #(
  parameter int MAX_DIM = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  lls3d_stream_if.sink         in_ch,
  lls3d_result_if.source       out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [lls3d_pkg::CFG_WIDTH-1:0] cfg_data
);
  localparam int NCELL = 14;
  localparam int PAD = MAX_DIM + 2;
  localparam int DEPTH = 2 * PAD * PAD + 2 * PAD + 3;
  // room for the stencil plus the words written while the last read waits
  localparam int AW = $clog2(DEPTH + 4 * NCELL);
  localparam int LAT = 3 * NCELL + 1;
  localparam int DW = $clog2(MAX_DIM + 2);
  localparam int AWX = 2 * AW;

  // configuration registers
  lls3d_pkg::lattice_mode_t mode;
  logic [6:0] dim_x, dim_y, dim_z;
  logic signed [31:0] coef_center, coef_x, coef_y, coef_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lls3d_pkg::MODE_ORTHO;
      dim_x <= 7'd64;
      dim_y <= 7'd64;
      dim_z <= 7'd64;
      coef_center <= '0;
      coef_x <= '0;
      coef_y <= '0;
      coef_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lls3d_pkg::REG_MODE:   mode <= lls3d_pkg::lattice_mode_t'(cfg_data[1:0]);
        lls3d_pkg::REG_DIM_X:  dim_x <= cfg_data[6:0];
        lls3d_pkg::REG_DIM_Y:  dim_y <= cfg_data[6:0];
        lls3d_pkg::REG_DIM_Z:  dim_z <= cfg_data[6:0];
        lls3d_pkg::REG_CENTER: coef_center <= cfg_data;
        lls3d_pkg::REG_COEF_X: coef_x <= cfg_data;
        lls3d_pkg::REG_COEF_Y: coef_y <= cfg_data;
        lls3d_pkg::REG_COEF_Z: coef_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions
  function automatic logic [DW-1:0] eff(input logic [6:0] d);
    logic [DW-1:0] r;
    if (d == 7'd0) r = DW'(1);
    else if (32'(d) > MAX_DIM) r = DW'(MAX_DIM);
    else r = DW'(d);
    return r;
  endfunction

  logic [DW-1:0] ex, ey, ez;
  assign ex = eff(dim_x);
  assign ey = eff(dim_y);
  assign ez = eff(dim_z);

  // last padded index on each axis
  logic [DW:0] ex1, ey1, ez1;
  assign ex1 = {1'b0, ex} + (DW+1)'(1);
  assign ey1 = {1'b0, ey} + (DW+1)'(1);
  assign ez1 = {1'b0, ez} + (DW+1)'(1);

  logic [AW-1:0] incy, incx, back;
  assign incy = AW'(ez) + AW'(2);
  assign incx = AW'((AWX)'(AW'(ey) + AW'(2)) * (AWX)'(incy));
  assign back = incx + incy + AW'(1);

  // pipeline control
  logic adv, take;
  logic [LAT-1:0] vld_sr, last_sr;
  logic out_valid;
  assign adv = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign take = in_ch.valid && adv;

  // position counters and write pointer
  logic [DW:0] px, py, pz;
  logic [AW-1:0] wptr;
  logic interior, lastp;
  assign interior = px >= (DW+1)'(2) && px <= ex1 && py >= (DW+1)'(2) && py <= ey1
                    && pz >= (DW+1)'(2) && pz <= ez1;
  assign lastp = px == ex1 && py == ey1 && pz == ez1;

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      pz <= '0;
      wptr <= '0;
    end else if (take) begin
      wptr <= wptr + AW'(1);
      if (pz >= ez1) begin
        pz <= '0;
        if (py >= ey1) begin
          py <= '0;
          px <= (px >= ex1) ? '0 : px + 1'b1;
        end else begin
          py <= py + 1'b1;
        end
      end else begin
        pz <= pz + 1'b1;
      end
    end
  end

  // address of one tap relative to the write pointer; the window wraps at a power of two
  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp, input logic [AW-1:0] k);
    return wp - k;
  endfunction

  // write pointer of each sample, carried along a delay line that advances with the row
  logic [AW-1:0] wp_dl [3*NCELL-2];
  always_ff @(posedge clk) begin
    if (adv) begin
      wp_dl[0] <= wptr;
      for (int j = 1; j < 3 * NCELL - 2; j++) wp_dl[j] <= wp_dl[j-1];
    end
  end

  // cell row: cell 0 is the center, cells 1..13 the taps
  logic signed [lls3d_pkg::ACC_WIDTH-1:0] acc [NCELL+1];
  logic [AW-1:0] raddr [NCELL];
  logic signed [31:0] wsel [NCELL];
  assign acc[0] = '0;

  genvar c;
  generate
    for (c = 0; c < NCELL; c++) begin : g_cell
      logic [5:0] off;
      logic signed [AW+1:0] ofs;
      if (c == 0) begin : g_ctr
        assign off = 6'b000000;
        assign wsel[c] = coef_center;
      end else begin : g_tap
        lls3d_pkg::coef_sel_t sel;
        assign off = lls3d_pkg::tap_off(mode, 4'(c - 1));
        assign sel = lls3d_pkg::tap_sel(mode, 4'(c - 1));
        always_comb begin
          case (sel)
            lls3d_pkg::SEL_X: wsel[c] = coef_x;
            lls3d_pkg::SEL_Y: wsel[c] = coef_y;
            lls3d_pkg::SEL_Z: wsel[c] = coef_z;
            default: wsel[c] = '0;
          endcase
        end
      end
      // back minus dx*incx + dy*incy + dz, as a positive lookback
      always_comb begin
        ofs = (AW+2)'(back);
        case (off[5:4])
          2'b01: ofs = ofs - (AW+2)'(incx);
          2'b11: ofs = ofs + (AW+2)'(incx);
          default: ;
        endcase
        case (off[3:2])
          2'b01: ofs = ofs - (AW+2)'(incy);
          2'b11: ofs = ofs + (AW+2)'(incy);
          default: ;
        endcase
        case (off[1:0])
          2'b01: ofs = ofs - (AW+2)'(1);
          2'b11: ofs = ofs + (AW+2)'(1);
          default: ;
        endcase
      end
      // lookback from the slot where the completing word was written
      assign raddr[c] = tap_addr(wp_dl[3*c], AW'(ofs));

      lls3d_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .AW(AW)) u_cell (
        .clk       (clk),
        .adv       (adv),
        .rd_en     (adv),
        .rd_addr   (raddr[c]),
        .wr_en     (take),
        .wr_addr   (wptr),
        .wr_data   (in_ch.data[SAMPLE_WIDTH-1:0]),
        .weight_in (wsel[c]),
        .acc_in    (acc[c]),
        .acc_out   (acc[c+1])
      );
    end
  endgenerate

  // valid and last flags travel alongside the row
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
      last_sr <= '0;
    end else if (adv) begin
      vld_sr <= {vld_sr[LAT-2:0], take && interior};
      last_sr <= {last_sr[LAT-2:0], lastp};
    end
  end

  // round half up, saturate
  logic signed [lls3d_pkg::ACC_WIDTH-1:0] rnd;
  logic signed [lls3d_pkg::ACC_WIDTH-17:0] shr;
  logic [SAMPLE_WIDTH-1:0] sat;
  localparam logic signed [lls3d_pkg::ACC_WIDTH-17:0] MAXV =
    (lls3d_pkg::ACC_WIDTH-16)'((64'(1) << (SAMPLE_WIDTH - 1)) - 1);
  assign rnd = acc[NCELL] + lls3d_pkg::ACC_WIDTH'(32'h8000);
  assign shr = rnd[lls3d_pkg::ACC_WIDTH-1:16];
  always_comb begin
    if (shr > MAXV) sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    else if (shr < -MAXV - 1) sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else sat = shr[SAMPLE_WIDTH-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_sr[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.laplacian <= sat;
      out_ch.last_point <= last_sr[LAT-1];
    end
  end
  assign out_ch.valid = out_valid;
endmodule

@@ rtl/lls3d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lls3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ rtl/lls3d_cell.sv @@
// One stencil cell: fetches a neighbor, multiplies by its weight, adds to the running sum.
module lls3d_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AW = 14
) (
  input  logic                                  clk,
  input  logic                                  adv,
  // address path: the read address for this cell; the RAM registers the read data
  input  logic                                  rd_en,
  input  logic [AW-1:0]                         rd_addr,
  input  logic                                  wr_en,
  input  logic [AW-1:0]                         wr_addr,
  input  logic [SAMPLE_WIDTH-1:0]               wr_data,
  input  logic signed [lls3d_pkg::COEF_WIDTH-1:0] weight_in,
  input  logic signed [lls3d_pkg::ACC_WIDTH-1:0]  acc_in,
  output logic signed [lls3d_pkg::ACC_WIDTH-1:0]  acc_out
);
  logic [SAMPLE_WIDTH-1:0] rdata;
  logic signed [lls3d_pkg::COEF_WIDTH-1:0] weight_d;
  logic signed [lls3d_pkg::ACC_WIDTH-1:0] acc_d;
  logic signed [SAMPLE_WIDTH+lls3d_pkg::COEF_WIDTH-1:0] prod;
  logic signed [lls3d_pkg::ACC_WIDTH-1:0] acc_mid;

  // each cell owns a copy of the window, so every neighbor has its own read port
  lls3d_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // stage 1: line up weight and incoming sum with the read data
  always_ff @(posedge clk) begin
    if (adv) begin
      weight_d <= weight_in;
      acc_d    <= acc_in;
    end
  end

  // stage 2: product registered, then summed
  always_ff @(posedge clk) begin
    if (adv) begin
      prod    <= $signed(rdata) * weight_d;
      acc_mid <= acc_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) acc_out <= acc_mid + lls3d_pkg::ACC_WIDTH'(prod);
  end
endmodule

@@ rtl/lls3d_checker.sv @@
// Port-level checks for the stencil engine, bound to the top level.
module lls3d_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  // the block never stalls input unless the output is blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready)) else $error("input stalled without backpressure");
  // a held result keeps its valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  // output valid is clear following any reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last && !out_ready) |=> out_last) else $error("last flag changed");
endmodule

bind lattice_laplacian_stencil_3d_top lls3d_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_point)
);

@@ verif/tb_stream_ifs.sv @@
// Testbench-side note: channel interfaces come from the RTL; this file holds the expected result word type.
`timescale 1ns / 100ps
package tb_lls3d_types_pkg;
  typedef struct {
    logic [31:0] laplacian;
    logic        last_point;
  } lap_result_t;
endpackage

@@ verif/tb_top.sv @@
// Self-checking testbench for the streaming 3D Laplacian stencil engine.
`timescale 1ns / 100ps
module tb_top;

  localparam int MAXD = 64;
  localparam int PADD = MAXD + 2;
  localparam int WDEPTH = 2 * PADD * PADD + 2 * PADD + 3;
  localparam int LATENCY = 3 * 14 + 1;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [lls3d_pkg::CFG_WIDTH-1:0] cfg_data;

  lls3d_stream_if #(.WIDTH(32)) in_ch (.clk(clk));
  lls3d_result_if #(.WIDTH(32)) out_ch (.clk(clk));

  lattice_laplacian_stencil_3d_top #(.MAX_DIM(MAXD), .SAMPLE_WIDTH(32)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Stencil predictor with its own window copy and register shadow
  class stencil_scoreboard;
    logic signed [31:0] win[WDEPTH];
    int wptr;
    int px, py, pz;
    lls3d_pkg::lattice_mode_t mode;
    logic [6:0] dx, dy, dz;
    logic signed [31:0] c_ctr, c_x, c_y, c_z;
    tb_lls3d_types_pkg::lap_result_t pending[$];
    int n_results;
    int n_errors;

    function void reset_state();
      wptr = 0; px = 0; py = 0; pz = 0;
      mode = lls3d_pkg::MODE_ORTHO; dx = 64; dy = 64; dz = 64;
      c_ctr = 0; c_x = 0; c_y = 0; c_z = 0;
      foreach (win[i]) win[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        lls3d_pkg::REG_MODE:   mode = lls3d_pkg::lattice_mode_t'(v[1:0]);
        lls3d_pkg::REG_DIM_X:  dx = v[6:0];
        lls3d_pkg::REG_DIM_Y:  dy = v[6:0];
        lls3d_pkg::REG_DIM_Z:  dz = v[6:0];
        lls3d_pkg::REG_CENTER: c_ctr = v;
        lls3d_pkg::REG_COEF_X: c_x = v;
        lls3d_pkg::REG_COEF_Y: c_y = v;
        lls3d_pkg::REG_COEF_Z: c_z = v;
        default: ;
      endcase
    endfunction

    function int clampdim(logic [6:0] d);
      if (d == 0) return 1;
      if (d > MAXD) return MAXD;
      return d;
    endfunction

    function logic signed [31:0] tap_val(int k);
      return win[(wptr + WDEPTH - (k % WDEPTH)) % WDEPTH];
    endfunction

    // weight for tap t of the current mode, with offset returned through output arguments
    function logic signed [31:0] tap_weight(int t, output int ox, output int oy,
                                             output int oz, output bit used);
      lls3d_pkg::coef_sel_t s;
      s = lls3d_pkg::SEL_NONE;
      used = 0; ox = 0; oy = 0; oz = 0;
      // own offset tables, same order as the lattice definitions
      case (mode)
        lls3d_pkg::MODE_ORTHO: begin
          int tx[6] = '{-1, 1, 0, 0, 0, 0};
          int ty[6] = '{0, 0, -1, 1, 0, 0};
          int tz[6] = '{0, 0, 0, 0, -1, 1};
          if (t < 6) begin
            used = 1; ox = tx[t]; oy = ty[t]; oz = tz[t];
            s = (t < 2) ? lls3d_pkg::SEL_X : (t < 4) ? lls3d_pkg::SEL_Y : lls3d_pkg::SEL_Z;
          end
        end
        lls3d_pkg::MODE_BCC: begin
          int tx[8] = '{-1, -1, 0, 0, 0, 0, 1, 1};
          int ty[8] = '{-1, 0, -1, 0, 0, 1, 0, 1};
          int tz[8] = '{-1, 0, 0, -1, 1, 0, 0, 1};
          if (t < 8) begin
            used = 1; ox = tx[t]; oy = ty[t]; oz = tz[t]; s = lls3d_pkg::SEL_X;
          end
        end
        lls3d_pkg::MODE_FCC: begin
          int tx[12] = '{-1, -1, -1, 0, 0, 0, 0, 0, 0, 1, 1, 1};
          int ty[12] = '{0, 0, 1, -1, -1, 0, 0, 1, 1, -1, 0, 0};
          int tz[12] = '{0, 1, 0, 0, 1, -1, 1, -1, 0, 0, -1, 0};
          if (t < 12) begin
            used = 1; ox = tx[t]; oy = ty[t]; oz = tz[t]; s = lls3d_pkg::SEL_X;
          end
        end
        default: begin
          int tx[8] = '{1, 1, 0, -1, -1, 0, 0, 0};
          int ty[8] = '{0, -1, -1, 0, 1, 1, 0, 0};
          int tz[8] = '{0, 0, 0, 0, 0, 0, -1, 1};
          if (t < 8) begin
            used = 1; ox = tx[t]; oy = ty[t]; oz = tz[t];
            s = (t < 6) ? lls3d_pkg::SEL_X : lls3d_pkg::SEL_Z;
          end
        end
      endcase
      case (s)
        lls3d_pkg::SEL_X: return c_x;
        lls3d_pkg::SEL_Y: return c_y;
        lls3d_pkg::SEL_Z: return c_z;
        default: return 0;
      endcase
    endfunction

    // note one accepted sample; queue the expected word if a stencil completes
    function void note_sample(logic [31:0] smp);
      int ex, ey, ez, incy, incx, back, ox, oy, oz;
      bit used;
      logic signed [111:0] acc;
      logic signed [111:0] rnd;
      logic signed [31:0] w;
      tb_lls3d_types_pkg::lap_result_t r;
      ex = clampdim(dx); ey = clampdim(dy); ez = clampdim(dz);
      incy = ez + 2; incx = (ey + 2) * incy; back = incx + incy + 1;
      win[wptr] = smp;
      if (px >= 2 && px <= ex + 1 && py >= 2 && py <= ey + 1 &&
          pz >= 2 && pz <= ez + 1) begin
        acc = 112'(tap_val(back)) * 112'(c_ctr);
        for (int t = 0; t < 13; t++) begin
          w = tap_weight(t, ox, oy, oz, used);
          if (used)
            acc += 112'(tap_val(back - (ox * incx + oy * incy + oz))) * 112'(w);
        end
        rnd = (acc + 112'sd32768) >>> 16;
        if (rnd > 112'sd2147483647) r.laplacian = 32'h7fffffff;
        else if (rnd < -112'sd2147483648) r.laplacian = 32'h80000000;
        else r.laplacian = rnd[31:0];
        r.last_point = (px == ex + 1 && py == ey + 1 && pz == ez + 1);
        pending.push_back(r);
      end
      wptr = (wptr + 1) % WDEPTH;
      if (pz >= ez + 1) begin
        pz = 0;
        if (py >= ey + 1) begin
          py = 0;
          px = (px >= ex + 1) ? 0 : px + 1;
        end else py++;
      end else pz++;
    endfunction

    function void check_word(logic [31:0] lap, logic lp);
      tb_lls3d_types_pkg::lap_result_t e;
      n_results++;
      if (pending.size() == 0) begin
        $error("unexpected result word laplacian=%h", lap);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (lap !== e.laplacian) begin
        $error("laplacian: expected %h actual %h", e.laplacian, lap);
        n_errors++;
      end
      if (lp !== e.last_point) begin
        $error("last_point: expected %b actual %b", e.last_point, lp);
        n_errors++;
      end
    endfunction
  endclass

  stencil_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  int n_samples;
  int n_grids;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog on acceptance activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("timeout: no traffic");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result sink with random stall
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else begin
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.laplacian, out_ch.last_point);
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic send_sample(logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.data <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(v);
    n_samples++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(32'h3ffff) - 32'h1ffff;
      default: return $urandom;
    endcase
  endfunction

  // one full grid with given mode and shape and random weights
  task automatic run_grid(lls3d_pkg::lattice_mode_t m, int x, int y, int z, int style);
    int total;
    write_cfg(lls3d_pkg::REG_MODE, 32'(m));
    write_cfg(lls3d_pkg::REG_DIM_X, x);
    write_cfg(lls3d_pkg::REG_DIM_Y, y);
    write_cfg(lls3d_pkg::REG_DIM_Z, z);
    write_cfg(lls3d_pkg::REG_CENTER, rand_word(style == 1 ? $urandom_range(4) : 3));
    write_cfg(lls3d_pkg::REG_COEF_X, rand_word(style == 1 ? $urandom_range(4) : 3));
    write_cfg(lls3d_pkg::REG_COEF_Y, rand_word(style == 1 ? $urandom_range(4) : 3));
    write_cfg(lls3d_pkg::REG_COEF_Z, rand_word(style == 1 ? $urandom_range(4) : 3));
    cfg_we <= 0;
    total = (sb.clampdim(x) + 2) * (sb.clampdim(y) + 2) * (sb.clampdim(z) + 2);
    for (int i = 0; i < total; i++)
      send_sample(style == 1 ? rand_word($urandom_range(4)) : rand_word($urandom_range(3, 4)));
    n_grids++;
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    idle_pct = 23;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_ch.valid = 0; in_ch.data = 0; out_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: smallest grid in three modes and a clamped fast axis in FCC, extreme weights and samples, odd dims
    run_grid(lls3d_pkg::MODE_ORTHO, 1, 1, 1, 1);
    run_grid(lls3d_pkg::MODE_BCC, 0, 0, 0, 1);
    run_grid(lls3d_pkg::MODE_FCC, 1, 1, 127, 1);
    run_grid(lls3d_pkg::MODE_HEX, 1, 1, 1, 1);

    // random grids, no idling for the first stretch
    idle_pct = 0;
    while (n_samples < 1000) run_grid(lls3d_pkg::lattice_mode_t'($urandom_range(3)),
      $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 5), $urandom_range(1));
    idle_pct = 23;
    while (n_samples < 1160) run_grid(lls3d_pkg::lattice_mode_t'($urandom_range(3)),
      $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 5), $urandom_range(1));
    // widest middle axis; the widest fast axis is covered by the clamped grid above
    run_grid(lls3d_pkg::MODE_ORTHO, 1, 64, 1, 0);

    $display("Covered %0d samples in %0d grids across all four lattices,", n_samples, n_grids);
    $display("checked %0d result words with random stalls on both sides.", sb.n_results);
    if (sb.n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
